// ===== hw/rtl/cusan_pkg.sv =====
// ---------------------------------------------------------------------------
// cusan_pkg: shared definitions for the color USAN edge detector
// Pixel format, register indexes, reset values and the color distance.
// ---------------------------------------------------------------------------
package cusan_pkg;

  localparam int PIX_W   = 24;
  localparam int CHAN_W  = 8;
  localparam int DIST_W  = 18;   // sum of three 8-bit squared differences

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int LINE_WIDTH_W = 12;
  localparam int THRESH_W     = 9;
  localparam int LIMIT_W      = 6;
  localparam int ROW_OUT_W    = 12;
  localparam int COL_OUT_W    = 11;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_THRESH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT  = 2'd2;

  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST   = 12'd640;
  localparam logic [THRESH_W-1:0]     COLOR_THRESH_RST = 9'd50;
  localparam logic [LIMIT_W-1:0]      COUNT_LIMIT_RST  = 6'd24;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int RADIUS_DEF     = 3;

  // Exact squared RGB distance between two packed pixels.
  // The difference is held at full distance width so its square does not wrap.
  function automatic logic [DIST_W-1:0] sq_dist(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    logic signed [DIST_W-1:0] d;
    logic [DIST_W-1:0]        sum;
    sum = '0;
    for (int ch = 0; ch < 3; ch++) begin
      d   = $signed({1'b0, a[ch*CHAN_W +: CHAN_W]}) - $signed({1'b0, b[ch*CHAN_W +: CHAN_W]});
      sum = sum + DIST_W'(unsigned'(d * d));
    end
    return sum;
  endfunction

endpackage

// ===== hw/rtl/cusan_ram.sv =====
// ---------------------------------------------------------------------------
// cusan_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read returns the old word.
// ---------------------------------------------------------------------------
module cusan_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/color_usan_edge_detector.sv =====
// ---------------------------------------------------------------------------
// color_usan_edge_detector: 7x7 color USAN edge marker over a raster stream
// Judges each interior pixel by how many window neighbors share its color.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream: one RGB pixel per beat in raster order; tuser marks the
//   first pixel of a frame and clears the row and column counters.
//   Master stream: one beat per judged center pixel carrying the edge mark
//   and the center's row and column. Border centers produce no beat.
//   Config port: cfg_we/cfg_index/cfg_data; user writes only while idle, unenforced.
//   Throughput: one pixel per cycle unless stalled. The line buffer is a single RAM,
//   one word per column holding all 2*RADIUS lines, read once and written
//   once per pixel; a write-to-read forward covers a column read right
//   after it was written (line width of one, or a one-pixel frame).
//   Pipeline: a pixel passes stages a, b, c and d, then the output register.
//   Reset: counters, pipeline valids and config registers return to defaults;
//   line and window storage is undefined until written by pixels.
//   Stall: the whole pipeline holds while the output beat waits, so
//   s_tready follows !m_tvalid || m_tready.
// ---------------------------------------------------------------------------
module color_usan_edge_detector
  import cusan_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int RADIUS     = RADIUS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,   // blue[7:0], green[15:8], red[23:16]
  input  logic                  s_tuser,   // first_of_frame
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // edge_mark[0], center_row[12:1],
                                           // center_column[23:13]
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SPAN  = 2 * RADIUS + 1;
  localparam int LINES = 2 * RADIUS;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int RCW   = $clog2(SPAN + 1);       // per-row similar count
  localparam int CNTW  = $clog2(SPAN * SPAN);    // total similar count
  localparam int CMPW  = (CNTW > LIMIT_W) ? CNTW : LIMIT_W;
  localparam int WIDW  = (CW + 1 > LINE_WIDTH_W) ? CW + 1 : LINE_WIDTH_W;

  // Configuration registers.
  logic [LINE_WIDTH_W-1:0] line_width;
  logic [THRESH_W-1:0]     color_threshold;
  logic [LIMIT_W-1:0]      similar_count_limit;
  logic [DIST_W-1:0]       thresh_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width          <= LINE_WIDTH_RST;
      color_threshold     <= COLOR_THRESH_RST;
      similar_count_limit <= COUNT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_WIDTH:   line_width          <= cfg_data[LINE_WIDTH_W-1:0];
        REG_COLOR_THRESH: color_threshold     <= cfg_data[THRESH_W-1:0];
        REG_COUNT_LIMIT:  similar_count_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Squared threshold reg; user keeps config quiet while pixels flow, unenforced.
  always_ff @(posedge clk) begin
    thresh_sq <= DIST_W'(color_threshold * color_threshold);
  end

  // Pipeline advance: everything moves when the output slot is free.
  logic en, accept;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign accept   = en && s_tvalid;

  // Raster counters, updated per accepted beat.
  logic [CW-1:0]   column_count, column_count_next, col;
  logic [RW-1:0]   row_count, row_count_next, row;
  logic [WIDW-1:0] width_eff;
  logic            emit;

  always_comb begin
    // Clamp the width: zero acts as one, oversize as MAX_WIDTH.
    if (line_width == '0) begin
      width_eff = WIDW'(1);
    end else if (WIDW'(line_width) > WIDW'(MAX_WIDTH)) begin
      width_eff = WIDW'(MAX_WIDTH);
    end else begin
      width_eff = WIDW'(line_width);
    end
    col = s_tuser ? '0 : column_count;
    row = s_tuser ? '0 : row_count;
    if (WIDW'(col) >= WIDW'(MAX_WIDTH)) begin
      col = '0;
    end
    if (RW <= WIDW) begin
      emit = (WIDW'(row) >= WIDW'(LINES)) && (WIDW'(col) >= WIDW'(LINES));
    end else begin
      emit = (row >= RW'(LINES)) && (WIDW'(col) >= WIDW'(LINES));
    end
    if (WIDW'(col) + WIDW'(1) >= width_eff) begin
      column_count_next = '0;
      row_count_next    = (row < RW'(MAX_HEIGHT - 1)) ? row + RW'(1) : row;
    end else begin
      column_count_next = col + CW'(1);
      row_count_next    = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Stage a: line buffer read in flight.
  logic             a_valid, a_emit;
  logic [PIX_W-1:0] a_pix;
  logic [CW-1:0]    a_col;
  logic [RW-1:0]    a_row;

  // Line buffer: one word per column, line i in bits [i*PIX_W +: PIX_W].
  logic [LINES*PIX_W-1:0] lb_rdata, lb_wdata, lb_word, fwd_data;
  logic                   fwd;
  logic                   lb_we;

  assign lb_word  = fwd ? fwd_data : lb_rdata;
  // Drop the oldest line, push the new pixel in as the youngest.
  assign lb_wdata = {a_pix, lb_word[LINES*PIX_W-1:PIX_W]};
  assign lb_we    = en && a_valid;

  cusan_ram #(
    .WIDTH (LINES * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (lb_we),
    .waddr (a_col),
    .wdata (lb_wdata),
    .re    (accept),
    .raddr (col),
    .rdata (lb_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pix    <= s_tdata;
      a_col    <= col;
      a_row    <= row;
      a_emit   <= emit;
      // Forward a write that lands on the column being read this edge.
      fwd      <= lb_we && (a_col == col);
      fwd_data <= lb_wdata;
    end
  end

  // Stage b: window shift.
  logic [PIX_W-1:0] win [SPAN][SPAN];
  logic             b_valid, b_emit;
  logic [CW-1:0]    b_col;
  logic [RW-1:0]    b_row;

  always_ff @(posedge clk) begin
    if (en && a_valid) begin
      for (int i = 0; i < SPAN; i++) begin
        for (int j = 0; j < SPAN - 1; j++) begin
          win[i][j] <= win[i][j+1];
        end
        if (i < LINES) begin
          win[i][SPAN-1] <= lb_word[i*PIX_W +: PIX_W];
        end else begin
          win[i][SPAN-1] <= a_pix;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_emit <= a_emit;
      b_col  <= a_col;
      b_row  <= a_row;
    end
  end

  // Stage c: similarity flag per neighbor (center flag held low).
  logic          sim [SPAN][SPAN];
  logic          c_valid, c_emit;
  logic [CW-1:0] c_col;
  logic [RW-1:0] c_row;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SPAN; i++) begin
        for (int j = 0; j < SPAN; j++) begin
          sim[i][j] <= !(i == RADIUS && j == RADIUS) &&
                       (sq_dist(win[RADIUS][RADIUS], win[i][j]) < thresh_sq);
        end
      end
      c_emit <= b_valid && b_emit;
      c_col  <= b_col;
      c_row  <= b_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  // Stage d: per-row counts.
  logic [RCW-1:0] row_sim [SPAN];
  logic [RCW-1:0] row_sim_next [SPAN];
  logic           d_emit;
  logic [CW-1:0]  d_col;
  logic [RW-1:0]  d_row;

  always_comb begin
    for (int i = 0; i < SPAN; i++) begin
      row_sim_next[i] = '0;
      for (int j = 0; j < SPAN; j++) begin
        row_sim_next[i] = row_sim_next[i] + RCW'(sim[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SPAN; i++) begin
        row_sim[i] <= row_sim_next[i];
      end
      d_emit <= c_valid && c_emit;
      d_col  <= c_col;
      d_row  <= c_row;
    end
  end

  // Output stage: total, compare, hold beat until taken.
  logic [CNTW-1:0]     total;
  logic                edge_mark;
  logic [ROW_OUT_W-1:0] center_row;
  logic [COL_OUT_W-1:0] center_column;
  logic [RW-1:0]        row_less;
  logic [CW-1:0]        col_less;

  always_comb begin
    total = '0;
    for (int i = 0; i < SPAN; i++) begin
      total = total + CNTW'(row_sim[i]);
    end
    row_less = d_row - RW'(RADIUS);
    col_less = d_col - CW'(RADIUS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= d_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      edge_mark     <= CMPW'(total) <= CMPW'(similar_count_limit);
      center_row    <= ROW_OUT_W'(row_less);
      center_column <= COL_OUT_W'(col_less);
    end
  end

  assign m_tdata = {center_column, center_row, edge_mark};

endmodule
